// ===== sv/i2c_sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C slave frame checker: shared types and constants
// Event modes, verdict codes, register indexes, the frame snapshot type and
// the verdict function used at the end of a frame.
// ----------------------------------------------------------------------------
package i2c_sfc_pkg;

  // Event modes carried in tuser
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERDICT_PING   = 3'd0;
  localparam logic [2:0] VERDICT_LOADER = 3'd1;
  localparam logic [2:0] VERDICT_BAD    = 3'd2;
  localparam logic [2:0] VERDICT_XOR    = 3'd3;
  localparam logic [2:0] VERDICT_SELECT = 3'd4;
  localparam logic [2:0] VERDICT_FWD    = 3'd5;

  // Configuration register indexes
  localparam logic [0:0] REG_HEAD = 1'b0;
  localparam logic [0:0] REG_TAIL = 1'b1;

  localparam logic [7:0] HEAD_RESET = 8'h55;
  localparam logic [7:0] TAIL_RESET = 8'hAA;

  // Fixed markers of the ping and loader frames, and the select and minimum lengths
  localparam logic [7:0] MAGIC_HEAD = 8'h55;
  localparam logic [7:0] MAGIC_SIXTH = 8'hAA;
  localparam logic [7:0] PING_LEN   = 8'h04;
  localparam logic [7:0] LOADER_LEN = 8'h00;
  localparam logic [7:0] SELECT_LEN = 8'h05;
  localparam logic [7:0] MIN_LEN    = 8'h03;

  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] addr;
    logic [7:0] len;
    logic [7:0] sixth;
    logic [7:0] check;
    logic [7:0] last;
    logic [7:0] xsum;
    logic [7:0] asum;
  } frame_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic [7:0] sum;
  } judgement_t;

  function automatic judgement_t judge(frame_t f, logic [7:0] head, logic [7:0] tail,
                                       logic [7:0] cap);
    judgement_t j;
    logic [7:0] x;
    logic [7:0] s;
    logic [7:0] tail_got;
    logic [7:0] check_got;
    logic       magic;
    j.sum = 8'h00;
    magic = (f.first == MAGIC_HEAD) && (f.sixth == MAGIC_SIXTH);
    // The header bytes join the running XOR and sum only where they lie
    // before the check byte.
    x = f.xsum ^ f.first;
    s = f.asum + f.first;
    if (f.len > 8'd3) begin
      x = x ^ f.addr;
      s = s + f.addr;
    end
    if (f.len > 8'd4) begin
      x = x ^ f.len;
      s = s + f.len;
    end
    tail_got  = (f.len == 8'd3) ? f.len : f.last;
    check_got = (f.len == 8'd3) ? f.addr : ((f.len == 8'd4) ? f.len : f.check);
    priority if (magic && f.len == PING_LEN) begin
      j.verdict = VERDICT_PING;
    end else if (magic && f.len == LOADER_LEN) begin
      j.verdict = VERDICT_LOADER;
    end else if (f.len < MIN_LEN || f.len > cap) begin
      j.verdict = VERDICT_BAD;
    end else if (f.first != head || tail_got != tail) begin
      j.verdict = VERDICT_BAD;
    end else if (x != check_got) begin
      j.verdict = VERDICT_XOR;
    end else if (f.len == SELECT_LEN) begin
      j.verdict = VERDICT_SELECT;
    end else begin
      j.verdict = VERDICT_FWD;
      j.sum = s;
    end
    return j;
  endfunction

endpackage

// ===== sv/i2c_sfc_frame.sv =====
// ----------------------------------------------------------------------------
// I2C slave frame checker: frame tracker
// Keeps the byte count, the header bytes, the sixth byte, the check and tail
// bytes and the running XOR and sum of the frame being received.
// ----------------------------------------------------------------------------
module i2c_sfc_frame #(
  parameter int unsigned FRAME_CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2c_sfc_pkg::beat_t  beat_i,
  output i2c_sfc_pkg::frame_t frame_o
);

  localparam logic [6:0] CapCount = 7'(FRAME_CAPACITY);

  logic [6:0]          count_q, count_d;
  i2c_sfc_pkg::frame_t frame_q, frame_d;
  logic [8:0]          pos_ext;
  logic [8:0]          len_ext;

  assign pos_ext = {2'b00, count_q};
  assign len_ext = {1'b0, frame_q.len};

  always_comb begin
    count_d = count_q;
    frame_d = frame_q;
    if (beat_i.valid) begin
      unique case (beat_i.mode)
        i2c_sfc_pkg::MODE_START, i2c_sfc_pkg::MODE_STOP: begin
          count_d = '0;
          frame_d = '0;
        end
        i2c_sfc_pkg::MODE_BYTE: begin
          // Bytes beyond the capacity are dropped.
          if (count_q < CapCount) begin
            count_d = count_q + 7'd1;
            priority if (count_q == 7'd0) begin
              frame_d.first = beat_i.data;
            end else if (count_q == 7'd1) begin
              frame_d.addr = beat_i.data;
            end else if (count_q == 7'd2) begin
              frame_d.len = beat_i.data;
            end else begin
              if (count_q == 7'd5) frame_d.sixth = beat_i.data;
              if (pos_ext + 9'd2 < len_ext) begin
                frame_d.xsum = frame_q.xsum ^ beat_i.data;
                frame_d.asum = frame_q.asum + beat_i.data;
              end
              if (pos_ext + 9'd2 == len_ext) frame_d.check = beat_i.data;
              if (pos_ext + 9'd1 == len_ext) frame_d.last = beat_i.data;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      frame_q <= '0;
    end else begin
      count_q <= count_d;
      frame_q <= frame_d;
    end
  end

  assign frame_o = frame_q;

endmodule

// ===== sv/i2c_slave_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// I2C slave frame checker
// Collects the start, byte and stop events of an I2C slave and gives one
// verdict beat for every stop.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock. An accepted beat sits in the
// input register and is then applied to the frame state; a stop turns
// into a verdict beat in the output register once it leaves the input
// register, and the verdict is offered on the master side from there.
// Input is held off only while the output register holds an untaken
// verdict and the next stop is waiting behind it.
// Start and byte events give no output beat; mode 3 is ignored. Head and tail
// bytes are configured through the write port and should be changed only
// between frames.
module i2c_slave_frame_checker_top #(
  parameter int unsigned FRAME_CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] verdict, [10:3] address_field, [18:11] frame_length,
  // [26:19] byte_sum, [31:27] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [7:0] CapLen = 8'(FRAME_CAPACITY);

  logic                    in_valid_q, in_valid_d;
  logic [1:0]              in_mode_q, in_mode_d;
  logic [7:0]              in_data_q, in_data_d;
  logic                    out_valid_q, out_valid_d;
  logic [26:0]             out_data_q, out_data_d;
  logic [7:0]              head_q, tail_q;
  logic                    advance;
  logic                    is_stop;
  i2c_sfc_pkg::beat_t      step;
  i2c_sfc_pkg::frame_t     frame;
  i2c_sfc_pkg::judgement_t jdg;

  assign is_stop = (in_mode_q == i2c_sfc_pkg::MODE_STOP);
  // A stop may only move on when the output register is free or being emptied.
  assign advance = in_valid_q && (!is_stop || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign step.valid = advance;
  assign step.mode  = in_mode_q;
  assign step.data  = in_data_q;

  i2c_sfc_frame #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (step),
    .frame_o(frame)
  );

  assign jdg = i2c_sfc_pkg::judge(frame, head_q, tail_q, CapLen);

  always_comb begin
    in_valid_d = in_valid_q;
    in_mode_d  = in_mode_q;
    in_data_d  = in_data_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_mode_d  = s_axis_tuser;
      in_data_d  = s_axis_tdata;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance && is_stop) begin
      out_valid_d = 1'b1;
      out_data_d  = {jdg.sum, frame.len, frame.addr, jdg.verdict};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_mode_q  <= in_mode_d;
    in_data_q  <= in_data_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= i2c_sfc_pkg::HEAD_RESET;
      tail_q <= i2c_sfc_pkg::TAIL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        i2c_sfc_pkg::REG_HEAD: head_q <= cfg_data_i;
        i2c_sfc_pkg::REG_TAIL: tail_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_data_q};

endmodule
